>>> rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// No dependencies; every other file of the block uses this package.
package bpa_pkg;

    localparam int ADDR_W   = 48;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int RANGE_W  = 4;
    localparam int BYTE_W   = 8;

    // Page geometry is fixed: page size must stay a power of two.
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
    localparam int HEADER_BYTES = 24;

    localparam int DEF_NUM_RANGES      = 8;
    localparam int DEF_PAGES_PER_RANGE = 4096;

    // Region bases at or below this address are ignored.
    localparam logic [ADDR_W-1:0] LOW_LIMIT = 48'h0000_0001_0000;
    localparam logic [BYTE_W-1:0] BIT_MSB   = 8'b1000_0000;

    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_IGNORED   = 3'd1,
        STS_FULL      = 3'd2,
        STS_NO_MEM    = 3'd3,
        STS_BAD_RANGE = 3'd4,
        STS_BAD_ADDR  = 3'd5
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

>>> rtl/bpa_if.sv
// Valid/ready channels of the bitmap page allocator: request and response.
// Depends on bpa_pkg for field widths.
interface bpa_req_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::CMD_W-1:0]    cmd;
    logic                         region_free;
    logic [bpa_pkg::ADDR_W-1:0]   region_base;
    logic [bpa_pkg::ADDR_W-1:0]   region_size;
    logic [bpa_pkg::RANGE_W-1:0]  release_range;
    logic [bpa_pkg::ADDR_W-1:0]   release_address;

    modport source (
        output valid, cmd, region_free, region_base, region_size,
               release_range, release_address,
        input  ready
    );
    modport sink (
        input  valid, cmd, region_free, region_base, region_size,
               release_range, release_address,
        output ready
    );
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::STATUS_W-1:0]  status;
    logic [bpa_pkg::ADDR_W-1:0]    page_address;
    logic [bpa_pkg::RANGE_W-1:0]   from_region;

    modport source (
        output valid, status, page_address, from_region,
        input  ready
    );
    modport sink (
        input  valid, status, page_address, from_region,
        output ready
    );
endinterface

>>> rtl/bpa_alu.sv
// Shared 48-bit add/subtract unit with carry out, used by the add-check, allocate-address and release steps.
// Depends on bpa_pkg (t_alu_req).
module bpa_alu (
    input  bpa_pkg::t_alu_req           i_req,
    output logic [bpa_pkg::ADDR_W-1:0]  o_sum,
    output logic                        o_carry
);
    import bpa_pkg::*;

    logic [ADDR_W-1:0] b_op;
    logic [ADDR_W:0]   full;

    // Subtract as a + ~b + 1; carry high means no borrow (a >= b).
    assign b_op = i_req.sub ? ~i_req.b : i_req.b;
    assign full = {1'b0, i_req.a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, i_req.sub};
    assign o_sum   = full[ADDR_W-1:0];
    assign o_carry = full[ADDR_W];

endmodule

>>> rtl/bpa_bitmap.sv
// Page usage bitmap store: one write port, one read port, registered read data.
// Depends on bpa_pkg for the byte width.
module bpa_bitmap #(
    parameter int AW = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [bpa_pkg::BYTE_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [bpa_pkg::BYTE_W-1:0]  o_rdata
);
    import bpa_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: sequencer, region tables, response register.
// Depends on bpa_pkg, bpa_if (channels), bpa_alu and bpa_bitmap.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+------------------------------------------------
//   i_req    | in  | valid / ready  | cmd, region_free, region_base, region_size,
//            |     |                | release_range, release_address
//   o_rsp    | out | valid / ready  | status, page_address, from_region
//
// One word at a time; i_req.ready is high only while the sequencer is idle.
// Add: clears the region's bitmap one byte a cycle through the single write port.
// Allocate: visits the regions in turn and scans each bitmap byte by byte. Release:
// checks range and address, then clears the page's bit. Others go to the response.
// A finished word waits in the response register; a stalled o_rsp holds the
// sequencer in its last step. Reset needs no clearing pass.
module bitmap_page_allocator #(
    parameter int NUM_RANGES      = bpa_pkg::DEF_NUM_RANGES,
    parameter int PAGES_PER_RANGE = bpa_pkg::DEF_PAGES_PER_RANGE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpa_req_if.sink     i_req,
    bpa_rsp_if.source   o_rsp
);
    import bpa_pkg::*;

    localparam int BYTES_PER_RANGE = (PAGES_PER_RANGE + 7) / 8;
    localparam int BW = (BYTES_PER_RANGE > 1) ? $clog2(BYTES_PER_RANGE) : 1;
    localparam int RW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int CW = $clog2(NUM_RANGES + 1);
    localparam int PW = $clog2(PAGES_PER_RANGE + 1);
    localparam int XW = PW + 4;
    localparam int AW = RW + BW;
    localparam int SW = ADDR_W - PAGE_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_CHK, S_ADD_SET, S_ADD_CLR,
        S_ALC_REG, S_ALC_CHK, S_ALC_ADDR,
        S_REL_CHK, S_REL_SUB, S_REL_HDR, S_REL_USE, S_REL_WR,
        S_RESP
    } t_state;

    t_state r_state;

    // Latched request
    logic                r_free_flag;
    logic [ADDR_W-1:0]   r_base;
    logic [ADDR_W-1:0]   r_size;
    logic [RANGE_W-1:0]  r_rel_range;
    logic [ADDR_W-1:0]   r_rel_addr;

    // Region tables
    logic [CW-1:0]       r_count;
    logic [ADDR_W-1:0]   r_start  [NUM_RANGES];
    logic [PW-1:0]       r_hdr    [NUM_RANGES];
    logic [PW-1:0]       r_free   [NUM_RANGES];
    logic [PW-1:0]       r_usable [NUM_RANGES];

    // Working registers
    logic [CW-1:0]       r_ridx;
    logic [BW-1:0]       r_byte;
    logic [2:0]          r_bit;
    logic [XW-1:0]       r_pg;
    logic [ADDR_W-1:0]   r_diff;

    // Pending result and response register
    t_status             r_res_status;
    logic [ADDR_W-1:0]   r_res_addr;
    logic [RANGE_W-1:0]  r_res_from;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [RANGE_W-1:0]  r_out_from;

    logic [RW-1:0]       idx;
    t_alu_req            alu_req;
    logic [ADDR_W-1:0]   alu_sum;
    logic                alu_carry;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [BYTE_W-1:0]   mem_rdata;

    logic [SW-1:0]       size_pages;
    logic [PW-1:0]       add_pages;
    logic [31:0]         hdr_sum;
    logic [PW-1:0]       add_hdr;
    logic [PW-1:0]       add_usable;

    logic                bit_found;
    logic [2:0]          bit_sel;
    logic                more_bytes;
    logic                rsp_free;

    assign idx = r_ridx[RW-1:0];

    bpa_alu u_alu (
        .i_req   (alu_req),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    bpa_bitmap #(
        .AW (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Region geometry for an add: clamp page count, size header, saturate usable.
    always_comb begin
        size_pages = r_size[ADDR_W-1:PAGE_SHIFT];
        if (size_pages > SW'(PAGES_PER_RANGE)) begin
            add_pages = PW'(PAGES_PER_RANGE);
        end else begin
            add_pages = size_pages[PW-1:0];
        end
        hdr_sum = 32'(HEADER_BYTES) + 32'(add_pages >> 3) + 32'(PAGE_BYTES - 1);
        add_hdr = PW'(hdr_sum >> PAGE_SHIFT);
        add_usable = (add_pages > add_hdr) ? (add_pages - add_hdr) : '0;
    end

    // First clear bit of the current byte, MSB first, within the usable pages.
    always_comb begin
        bit_found = 1'b0;
        bit_sel   = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (!mem_rdata[7-k] && (XW'({r_byte, 3'(k)}) < XW'(r_usable[idx]))) begin
                bit_found = 1'b1;
                bit_sel   = 3'(k);
            end
        end
        more_bytes = ((XW'(r_byte) + XW'(1)) << 3) < XW'(r_usable[idx]);
    end

    always_comb begin
        alu_req = '0;
        case (r_state)
            S_ADD_CHK: begin
                alu_req.a   = r_base;
                alu_req.b   = LOW_LIMIT + 48'd1;
                alu_req.sub = 1'b1;
            end
            S_ALC_ADDR: begin
                alu_req.a = r_start[idx];
                alu_req.b = ADDR_W'(r_pg) << PAGE_SHIFT;
            end
            S_REL_SUB: begin
                alu_req.a   = r_rel_addr;
                alu_req.b   = r_start[idx];
                alu_req.sub = 1'b1;
            end
            S_REL_HDR: begin
                alu_req.a   = r_diff >> PAGE_SHIFT;
                alu_req.b   = ADDR_W'(r_hdr[idx]);
                alu_req.sub = 1'b1;
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {idx, r_byte};
        mem_wdata = '0;
        mem_raddr = {idx, r_byte};
        case (r_state)
            S_ADD_CLR: mem_we = 1'b1;
            // fetch the region's first byte ahead of the scan
            S_ALC_REG: mem_raddr = {idx, BW'(0)};
            S_ALC_CHK: begin
                // fetch the next byte while checking this one
                mem_raddr = {idx, r_byte + BW'(1)};
                mem_we    = bit_found;
                mem_wdata = mem_rdata | (BIT_MSB >> bit_sel);
            end
            S_REL_USE: mem_raddr = {idx, r_diff[BW+2:3]};
            S_REL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~(BIT_MSB >> r_bit);
            end
            default: mem_we = 1'b0;
        endcase
    end

    assign rsp_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_free_flag  <= i_req.region_free;
                        r_base       <= i_req.region_base;
                        r_size       <= i_req.region_size;
                        r_rel_range  <= i_req.release_range;
                        r_rel_addr   <= i_req.release_address;
                        r_res_status <= STS_OK;
                        r_res_addr   <= '0;
                        r_res_from   <= '0;
                        r_ridx       <= '0;
                        case (i_req.cmd)
                            CMD_ADD:     r_state <= S_ADD_CHK;
                            CMD_ALLOC:   r_state <= S_ALC_REG;
                            CMD_RELEASE: r_state <= S_REL_CHK;
                            default: begin
                                r_res_status <= STS_IGNORED;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ADD_CHK: begin
                    if (!r_free_flag || !alu_carry) begin
                        r_res_status <= STS_IGNORED;
                        r_state      <= S_RESP;
                    end else if (r_count >= CW'(NUM_RANGES)) begin
                        r_res_status <= STS_FULL;
                        r_state      <= S_RESP;
                    end else begin
                        r_ridx  <= r_count;
                        r_state <= S_ADD_SET;
                    end
                end
                S_ADD_SET: begin
                    r_start[idx]  <= r_base;
                    r_hdr[idx]    <= add_hdr;
                    r_usable[idx] <= add_usable;
                    r_free[idx]   <= add_usable;
                    r_byte        <= '0;
                    r_state       <= S_ADD_CLR;
                end
                S_ADD_CLR: begin
                    if (r_byte == BW'(BYTES_PER_RANGE - 1)) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_RESP;
                    end else begin
                        r_byte <= r_byte + BW'(1);
                    end
                end
                S_ALC_REG: begin
                    if (r_ridx >= r_count) begin
                        r_res_status <= STS_NO_MEM;
                        r_state      <= S_RESP;
                    end else if (r_free[idx] == '0) begin
                        r_ridx <= r_ridx + CW'(1);
                    end else begin
                        r_byte  <= '0;
                        r_state <= S_ALC_CHK;
                    end
                end
                S_ALC_CHK: begin
                    if (bit_found) begin
                        r_free[idx] <= r_free[idx] - PW'(1);
                        r_pg        <= XW'({r_byte, bit_sel}) + XW'(r_hdr[idx]);
                        r_state     <= S_ALC_ADDR;
                    end else if (more_bytes) begin
                        r_byte <= r_byte + BW'(1);
                    end else begin
                        // region exhausted despite its free count: skip it
                        r_ridx  <= r_ridx + CW'(1);
                        r_state <= S_ALC_REG;
                    end
                end
                S_ALC_ADDR: begin
                    r_res_addr <= alu_sum;
                    r_res_from <= RANGE_W'(r_ridx);
                    r_state    <= S_RESP;
                end
                S_REL_CHK: begin
                    if (5'(r_rel_range) >= 5'(r_count)) begin
                        r_res_status <= STS_BAD_RANGE;
                        r_state      <= S_RESP;
                    end else begin
                        r_ridx  <= CW'(r_rel_range);
                        r_state <= S_REL_SUB;
                    end
                end
                S_REL_SUB: begin
                    if (!alu_carry) begin
                        r_res_status <= STS_BAD_ADDR;
                        r_state      <= S_RESP;
                    end else begin
                        r_diff  <= alu_sum;
                        r_state <= S_REL_HDR;
                    end
                end
                S_REL_HDR: begin
                    if (!alu_carry) begin
                        r_res_status <= STS_BAD_ADDR;
                        r_state      <= S_RESP;
                    end else begin
                        r_diff  <= alu_sum;
                        r_state <= S_REL_USE;
                    end
                end
                S_REL_USE: begin
                    if (r_diff >= ADDR_W'(r_usable[idx])) begin
                        r_res_status <= STS_BAD_ADDR;
                        r_state      <= S_RESP;
                    end else begin
                        r_byte  <= r_diff[BW+2:3];
                        r_bit   <= r_diff[2:0];
                        r_state <= S_REL_WR;
                    end
                end
                S_REL_WR: begin
                    if (r_free[idx] < r_usable[idx]) begin
                        r_free[idx] <= r_free[idx] + PW'(1);
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // hold until the response register is free
                    if (rsp_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_addr   <= r_res_addr;
                        r_out_from   <= r_res_from;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.page_address = r_out_addr;
    assign o_rsp.from_region  = r_out_from;

endmodule
